@@ hdl/cecu_pkg.sv @@
`timescale 1ns / 1ps

package cecu_pkg;

  localparam int DATA_W    = 32;
  localparam int OFF_W     = 9;
  localparam int CODE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int MAX_SLOTS = 8;

  // Stream widths: input tdata is reg_offset, write_data, event_code, padded to bytes
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = DATA_W;
  localparam int M_TUSER_W = 1;

  // Register map, byte offsets
  localparam logic [OFF_W-1:0] OFF_CONTROL = 9'h004;
  localparam logic [OFF_W-1:0] OFF_SELECT0 = 9'h140;
  localparam logic [OFF_W-1:0] OFF_SELECT1 = 9'h144;
  localparam logic [OFF_W-1:0] OFF_COUNTER = 9'h170;

  localparam logic [DATA_W-1:0] ENABLE_MASK = 32'h0100_0000;
  localparam logic [CODE_W-1:0] SELECT_OFF  = 8'hff;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [CODE_W-1:0] event_code;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bad_offset;
  } rsp_t;

endpackage

@@ hdl/cache_event_counter_unit_core.sv @@
`timescale 1ns / 1ps

// Cache event counter unit: up to eight event counters behind a small register map
// (control at 0x004 with enable in bit 24, select bytes at 0x140/0x144, counters at
// 0x170 + 4*i). Each input item is a register read, a register write, one cache
// event or an unused kind that changes nothing; each gives exactly one result item.
// The block takes one item per clock when not stalled: an input register feeds the
// decode and counter update, whose answer lands in an output register. s_axis_tready
// drops only while a result sits in the output register with m_axis_tready low. All
// state is ready once rst is released; select bytes reset to 0xff (counting off).

module cache_event_counter_unit_core
  import cecu_pkg::*;
#(
  parameter int N_EVT_CNT  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [8:0] reg_offset, [40:9] write_data, [48:41] event_code, [55:49] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] read_data
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] bad_offset
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  logic              in_valid;
  kind_t             in_kind;
  logic [OFF_W-1:0]  in_offset;
  logic [DATA_W-1:0] in_wdata;
  logic [CODE_W-1:0] in_code;

  logic out_load;
  logic proc;
  req_t req;
  rsp_t rsp;

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign proc          = in_valid && out_load;
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind   <= kind_t'(s_axis_tuser[KIND_W-1:0]);
      in_offset <= s_axis_tdata[OFF_W-1:0];
      in_wdata  <= s_axis_tdata[OFF_W +: DATA_W];
      in_code   <= s_axis_tdata[OFF_W+DATA_W +: CODE_W];
    end
  end

  always_comb begin
    req.valid      = proc;
    req.kind       = in_kind;
    req.reg_offset = in_offset;
    req.write_data = in_wdata;
    req.event_code = in_code;
  end

  cecu_regfile #(
    .N_EVT_CNT  (N_EVT_CNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_regfile (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_axis_tdata <= rsp.read_data;
      m_axis_tuser <= rsp.bad_offset;
    end
  end

endmodule

@@ hdl/cecu_regfile.sv @@
`timescale 1ns / 1ps

module cecu_regfile
  import cecu_pkg::*;
#(
  parameter int N_EVT_CNT  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output rsp_t rsp
);

  logic [DATA_W-1:0]     control_word;
  logic [CODE_W-1:0]     event_select [MAX_SLOTS];
  logic [COUNT_BITS-1:0] event_counts [MAX_SLOTS];

  logic              is_access;
  logic              is_write;
  logic              is_ctrl;
  logic              is_sel0;
  logic              is_sel1;
  logic              in_cnt_range;
  logic [OFF_W-1:0]  cnt_rel;
  logic [MAX_SLOTS-1:0] cnt_hit;
  logic              count_en;
  logic [DATA_W-1:0] cnt_rdata;

  assign is_access    = (req.kind == KIND_READ) || (req.kind == KIND_WRITE);
  assign is_write     = req.valid && (req.kind == KIND_WRITE);
  assign is_ctrl      = (req.reg_offset == OFF_CONTROL);
  assign is_sel0      = (req.reg_offset == OFF_SELECT0);
  assign is_sel1      = (req.reg_offset == OFF_SELECT1);
  assign cnt_rel      = req.reg_offset - OFF_COUNTER;
  assign in_cnt_range = (req.reg_offset >= OFF_COUNTER) && (req.reg_offset[1:0] == 2'b00);
  assign count_en     = req.valid && (req.kind == KIND_EVENT)
                        && ((control_word & ENABLE_MASK) != '0)
                        && (req.event_code != SELECT_OFF);

  always_comb begin
    cnt_rdata = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cnt_hit[i] = in_cnt_range && (i < N_EVT_CNT)
                   && (cnt_rel[OFF_W-1:2] == (OFF_W-2)'(i));
      if (cnt_hit[i]) begin
        cnt_rdata = cnt_rdata | DATA_W'(event_counts[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= '0;
    end else if (is_write && is_ctrl) begin
      control_word <= req.write_data;
    end
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
    if (i < N_EVT_CNT) begin : g_built
      always_ff @(posedge clk) begin
        if (rst) begin
          event_select[i] <= SELECT_OFF;
        end else if (is_write && ((i < 4) ? is_sel0 : is_sel1)) begin
          event_select[i] <= req.write_data[8*(i%4) +: CODE_W];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          event_counts[i] <= '0;
        end else if (is_write && cnt_hit[i]) begin
          event_counts[i] <= req.write_data[COUNT_BITS-1:0];
        end else if (count_en && (event_select[i] == req.event_code)) begin
          event_counts[i] <= event_counts[i] + COUNT_BITS'(1);
        end
      end
    end else begin : g_absent
      // Missing counters read as disabled and never count
      assign event_select[i] = SELECT_OFF;
      assign event_counts[i] = '0;
    end
  end

  always_comb begin
    rsp = '0;
    if (is_access) begin
      priority if (is_ctrl) begin
        rsp.read_data = control_word;
      end else if (is_sel0) begin
        rsp.read_data = {event_select[3], event_select[2], event_select[1], event_select[0]};
      end else if (is_sel1) begin
        rsp.read_data = {event_select[7], event_select[6], event_select[5], event_select[4]};
      end else if (cnt_hit != '0) begin
        rsp.read_data = cnt_rdata;
      end else begin
        rsp.bad_offset = 1'b1;
      end
      // Writes return zero data
      if (req.kind == KIND_WRITE) begin
        rsp.read_data = '0;
      end
    end
  end

endmodule

@@ hdl/cecu_checker.sv @@
`timescale 1ns / 1ps

module cecu_checker
  import cecu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // No result may appear in the cycle after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An empty output register must never block the input side
  assert property (@(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A bad offset always comes with zero data
  assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("bad_offset with nonzero read_data");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind cache_event_counter_unit_core cecu_checker u_cecu_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cecu_pkg::*;

  localparam int N_CNT = 8;
  localparam int CNT_BITS = 32;
  localparam logic [DATA_W-1:0] CNT_MASK = 32'((64'd1 << CNT_BITS) - 64'd1);
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int LIMIT = 200000;
  localparam int HOLD_CYC = 60;
  localparam int N_DIR = 26;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] wdata;
    logic [CODE_W-1:0] code;
    bit                typed;
    logic [DATA_W-1:0] rdata;
    logic              bad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // mirror of the monitor registers
  logic [CODE_W-1:0] sel_byte [N_CNT];
  logic [DATA_W-1:0] ctrl_word;
  logic [DATA_W-1:0] evt_count [N_CNT];

  rsp_t pending_rsp [$];
  rsp_t want_rsp;
  int err_cnt = 0;
  int cyc = 0;
  int idle_pct = 0;
  bit hold_req = 1'b0;
  int n_rd = 0, n_wr = 0, n_ev = 0, n_none = 0, n_bad = 0, n_inc = 0;
  int n_hold = 0, n_pause = 0;

  // directed items; rows with typed set carry a hand-written result
  dir_row_t dir_tab [N_DIR] = '{
    '{KIND_READ,  OFF_CONTROL,          32'h0,         8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_READ,  OFF_SELECT0,          32'h0,         8'h00, 1'b1, 32'hffff_ffff, 1'b0},
    '{KIND_READ,  OFF_SELECT1,          32'h0,         8'h00, 1'b1, 32'hffff_ffff, 1'b0},
    '{KIND_READ,  OFF_COUNTER,          32'h0,         8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_READ,  OFF_COUNTER + 9'd28,  32'h0,         8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_EVENT, 9'h000,               32'h0,         8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_READ,  9'h000,               32'h0,         8'h00, 1'b1, 32'h0,         1'b1},
    '{KIND_READ,  OFF_COUNTER + 9'd1,   32'h0,         8'h00, 1'b1, 32'h0,         1'b1},
    '{KIND_WRITE, OFF_COUNTER + 9'd32,  32'hffff_ffff, 8'h00, 1'b1, 32'h0,         1'b1},
    '{KIND_WRITE, 9'h1ff,               32'hffff_ffff, 8'hff, 1'b1, 32'h0,         1'b1},
    '{KIND_WRITE, OFF_CONTROL,          32'hffff_ffff, 8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_READ,  OFF_CONTROL,          32'h0,         8'h00, 1'b1, 32'hffff_ffff, 1'b0},
    '{KIND_WRITE, OFF_SELECT0,          32'h0302_0100, 8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_WRITE, OFF_SELECT1,          32'h01ff_0000, 8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_WRITE, OFF_COUNTER + 9'd12,  32'hffff_ffff, 8'h00, 1'b1, 32'h0,         1'b0},
    '{KIND_EVENT, 9'h000,               32'h0,         8'h03, 1'b1, 32'h0,         1'b0},
    '{KIND_EVENT, 9'h000,               32'h0,         8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_EVENT, 9'h000,               32'h0,         8'hff, 1'b0, 32'h0,         1'b0},
    '{KIND_READ,  OFF_COUNTER + 9'd12,  32'h0,         8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_READ,  OFF_COUNTER + 9'd16,  32'h0,         8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_WRITE, OFF_CONTROL,          32'hfedc_ba98, 8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_EVENT, 9'h000,               32'h0,         8'h01, 1'b0, 32'h0,         1'b0},
    '{KIND_READ,  OFF_COUNTER + 9'd28,  32'h0,         8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_NONE,  9'h1ff,               32'hffff_ffff, 8'hff, 1'b1, 32'h0,         1'b0},
    '{KIND_READ,  OFF_SELECT1,          32'h0,         8'h00, 1'b0, 32'h0,         1'b0},
    '{KIND_WRITE, OFF_CONTROL,          ENABLE_MASK,   8'h00, 1'b0, 32'h0,         1'b0}
  };

  cache_event_counter_unit_core #(
    .N_EVT_CNT  (N_CNT),
    .COUNT_BITS (CNT_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cyc,
               pending_rsp.size());
      $display("FAIL cache_event_counter_unit_core");
      $finish;
    end
  end

  // Apply one item to the mirrored registers and return the result it gives.
  function automatic rsp_t apply_item(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] off,
                                      logic [DATA_W-1:0] wdata, logic [CODE_W-1:0] code);
    rsp_t r;
    int base;
    int slot;
    bit wr;
    r = '0;
    wr = (kind == KIND_WRITE);
    if (kind == KIND_READ || kind == KIND_WRITE) begin
      if (off == OFF_CONTROL) begin
        if (wr) ctrl_word = wdata;
        else r.read_data = ctrl_word;
      end else if (off == OFF_SELECT0 || off == OFF_SELECT1) begin
        base = (off == OFF_SELECT1) ? 4 : 0;
        for (int b = 0; b < 4; b++) begin
          if (base + b < N_CNT) begin
            if (wr) sel_byte[base + b] = wdata[8*b +: 8];
            else r.read_data[8*b +: 8] = sel_byte[base + b];
          end else if (!wr) begin
            r.read_data[8*b +: 8] = SELECT_OFF;
          end
        end
      end else if (off >= OFF_COUNTER && off[1:0] == 2'b00 &&
                   int'((off - OFF_COUNTER) >> 2) < N_CNT) begin
        slot = int'((off - OFF_COUNTER) >> 2);
        if (wr) evt_count[slot] = wdata & CNT_MASK;
        else r.read_data = evt_count[slot] & CNT_MASK;
      end else begin
        r.bad_offset = 1'b1;
      end
    end else if (kind == KIND_EVENT) begin
      if ((ctrl_word & ENABLE_MASK) != '0 && code != SELECT_OFF) begin
        for (int i = 0; i < N_CNT; i++) begin
          if (sel_byte[i] == code) begin
            evt_count[i] = (evt_count[i] + 1'b1) & CNT_MASK;
            n_inc++;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] pick_reg_offset();
    case ($urandom_range(0, 3))
      0: return OFF_CONTROL;
      1: return OFF_SELECT0;
      2: return OFF_SELECT1;
      default: return OFF_COUNTER + OFF_W'(4 * $urandom_range(0, N_CNT - 1));
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [OFF_W-1:0] off,
                           input logic [DATA_W-1:0] wdata, input logic [CODE_W-1:0] code,
                           input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, code, wdata, off};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p = apply_item(kind, off, wdata, code);
    pending_rsp.push_back(typed ? typed_rsp : p);
    case (kind)
      KIND_READ: n_rd++;
      KIND_WRITE: n_wr++;
      KIND_EVENT: n_ev++;
      default: n_none++;
    endcase
    if (p.bad_offset) n_bad++;
  endtask

  // Drop valid and hold off until every outstanding result is back.
  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    int pick;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0] off;
    logic [DATA_W-1:0] wdata;
    logic [CODE_W-1:0] code;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      off = OFF_W'($urandom);
      wdata = $urandom;
      code = CODE_W'($urandom);
      if (pick < 45) begin
        kind = KIND_EVENT;
        // mostly codes that some counter is watching
        case ($urandom_range(0, 5))
          0: ;
          1: code = CODE_W'($urandom_range(0, 7));
          default: code = sel_byte[$urandom_range(0, N_CNT - 1)];
        endcase
      end else if (pick < 68) begin
        kind = KIND_READ;
        off = pick_reg_offset();
      end else if (pick < 73) begin
        kind = KIND_READ;
      end else if (pick < 90) begin
        kind = KIND_WRITE;
        off = pick_reg_offset();
        if (off == OFF_CONTROL) begin
          if ($urandom_range(0, 9) != 0) wdata = wdata | ENABLE_MASK;
          else wdata = wdata & ~ENABLE_MASK;
        end else if (off == OFF_SELECT0 || off == OFF_SELECT1) begin
          for (int b = 0; b < 4; b++) begin
            case ($urandom_range(0, 5))
              0: wdata[8*b +: 8] = SELECT_OFF;
              1: ;
              default: wdata[8*b +: 8] = CODE_W'($urandom_range(0, 7));
            endcase
          end
        end else if ($urandom_range(0, 2) == 0) begin
          // park the counter near the top so it wraps soon
          wdata = CNT_MASK - DATA_W'($urandom_range(0, 15));
        end
      end else if (pick < 96) begin
        kind = KIND_WRITE;
      end else begin
        kind = KIND_NONE;
      end
      send_item(kind, off, wdata, code, 1'b0, '0);
    end
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
        n_hold++;
        m_axis_tready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected item: read_data %h bad_offset %b", $time, m_axis_tdata,
                 m_axis_tuser[0]);
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (m_axis_tdata !== want_rsp.read_data) begin
          err_cnt++;
          $display("%0t read_data mismatch: expected %h, actual %h", $time,
                   want_rsp.read_data, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== want_rsp.bad_offset) begin
          err_cnt++;
          $display("%0t bad_offset mismatch: expected %b, actual %b", $time,
                   want_rsp.bad_offset, m_axis_tuser[0]);
        end
      end
    end
  end

  initial begin
    rsp_t row_rsp;
    for (int i = 0; i < N_CNT; i++) begin
      sel_byte[i] = SELECT_OFF;
      evt_count[i] = '0;
    end
    ctrl_word = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    for (int r = 0; r < N_DIR; r++) begin
      row_rsp.read_data = dir_tab[r].rdata;
      row_rsp.bad_offset = dir_tab[r].bad;
      send_item(dir_tab[r].kind, dir_tab[r].off, dir_tab[r].wdata, dir_tab[r].code,
                dir_tab[r].typed, row_rsp);
    end
    wait_empty();
    n_pause++;

    for (int seg = 0; seg < 13; seg++) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (seg == 3) begin
        // keep offering items while the output side is held off
        idle_pct = 0;
        hold_req = 1'b1;
      end
      send_random(100);
      if (seg == 7) begin
        wait_empty();
        n_pause++;
      end
    end

    idle_pct = 0;
    send_random(250);
    wait_empty();
    repeat (16) @(posedge clk);

    $display("Covered %0d items: %0d reads, %0d writes, %0d events, %0d unused kind, %0d bad",
             n_rd + n_wr + n_ev + n_none, n_rd, n_wr, n_ev, n_none, n_bad);
    $display("Counted %0d increments; %0d long output holds, %0d input pauses to empty",
             n_inc, n_hold, n_pause);
    if (err_cnt == 0) begin
      $display("PASS cache_event_counter_unit_core");
    end else begin
      $display("FAIL cache_event_counter_unit_core");
    end
    $finish;
  end

endmodule

@@ cache_event_counter_unit_core.f @@
hdl/cecu_pkg.sv
hdl/cecu_regfile.sv
hdl/cache_event_counter_unit_core.sv
hdl/cecu_checker.sv
dv/tb_top.sv
